@@ hw/rtl/oal_pkg.sv @@
// Shared types and constants of the ordered array list.
package oal_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned OIDX_W     = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    F_INS_HEAD = 3'd0,
    F_INS_TAIL = 3'd1,
    F_INS_IDX  = 3'd2,
    F_DEL_HEAD = 3'd3,
    F_DEL_TAIL = 3'd4,
    F_READ     = 3'd5,
    F_FIND     = 3'd6,
    F_CLEAR    = 3'd7
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_MOVE_LAST,
    S_SCAN,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [IDX_W-1:0]  index;
    logic [ITEM_W-1:0] item;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ITEM_W-1:0] item;
    logic [OIDX_W-1:0] index;
    logic [LEN_W-1:0]  length;
  } res_t;

endpackage

@@ hw/rtl/oal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/oal_core.sv @@
// Command sequencer and shared address/compare unit of the ordered array list.
module oal_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  oal_pkg::cmd_t            cmd_i,
  input  logic [oal_pkg::CAP_W-1:0] cap_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output oal_pkg::res_t            res_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [ITEM_WIDTH-1:0]    ram_wdata_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [ITEM_WIDTH-1:0]    ram_rdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > oal_pkg::IDX_W) ? CW : oal_pkg::IDX_W;

  oal_pkg::state_e  state_q, state_d;
  oal_pkg::func_e   op_q, op_d;
  oal_pkg::status_e stat_q, stat_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic [AW-1:0]    ca_q, ca_d;
  logic [AW-1:0]    fidx_q, fidx_d;
  logic [ITEM_WIDTH-1:0] val_q, val_d;
  logic [ITEM_WIDTH-1:0] itm_q, itm_d;
  logic [CW-1:0]    count_q, count_d;
  logic             mv_q, mv_d;
  logic             cap_q, cap_d;
  logic             chk_q, chk_d;
  logic             lchk_q, lchk_d;

  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   last_a;
  logic [AW-1:0]   ins_pos;
  logic [CMPW-1:0] cnt_w, cap_w, idx_w, lim;
  logic            full, empty;
  logic [63:0]     item_wide, itm_ext, fidx_ext, cnt_ext;

  assign cnt_m1    = count_q - CW'(1);
  assign last_a    = cnt_m1[AW-1:0];
  assign cnt_w     = CMPW'(count_q);
  assign cap_w     = CMPW'(cap_i);
  assign idx_w     = CMPW'(cmd_i.index);
  assign lim       = (cap_w == '0 || cap_w > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_w;
  assign full      = (cnt_w >= lim);
  assign empty     = (count_q == '0);
  assign item_wide = {32'b0, cmd_i.item};

  always_comb begin
    case (cmd_i.func)
      oal_pkg::F_INS_HEAD: ins_pos = '0;
      oal_pkg::F_INS_TAIL: ins_pos = count_q[AW-1:0];
      default:             ins_pos = idx_w[AW-1:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    stat_d  = stat_q;
    pos_d   = pos_q;
    rd_d    = rd_q;
    wa_d    = wa_q;
    ca_d    = ca_q;
    fidx_d  = fidx_q;
    val_d   = val_q;
    itm_d   = itm_q;
    count_d = count_q;
    mv_d    = mv_q;
    cap_d   = cap_q;
    chk_d   = chk_q;
    lchk_d  = lchk_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = rd_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      oal_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d    = cmd_i.func;
          val_d   = item_wide[ITEM_WIDTH-1:0];
          stat_d  = oal_pkg::STAT_OK;
          itm_d   = '0;
          fidx_d  = '0;
          pos_d   = ins_pos;
          mv_d    = 1'b0;
          cap_d   = 1'b0;
          chk_d   = 1'b0;
          lchk_d  = 1'b0;
          state_d = oal_pkg::S_DONE;
          case (cmd_i.func)
            oal_pkg::F_INS_HEAD, oal_pkg::F_INS_TAIL, oal_pkg::F_INS_IDX: begin
              if (full) begin
                stat_d = oal_pkg::STAT_FULL;
              end else if (cmd_i.func == oal_pkg::F_INS_IDX && idx_w > cnt_w) begin
                stat_d = oal_pkg::STAT_RANGE;
              end else if (CMPW'(ins_pos) == cnt_w) begin
                state_d = oal_pkg::S_PUT;
              end else begin
                rd_d    = last_a;
                state_d = oal_pkg::S_SHIFT_UP;
              end
            end
            oal_pkg::F_DEL_HEAD: begin
              if (empty) begin
                stat_d = oal_pkg::STAT_EMPTY;
              end else begin
                rd_d    = '0;
                state_d = oal_pkg::S_SHIFT_DN;
              end
            end
            oal_pkg::F_DEL_TAIL: begin
              if (empty) begin
                stat_d = oal_pkg::STAT_EMPTY;
              end else begin
                rd_d    = last_a;
                state_d = oal_pkg::S_READ;
              end
            end
            oal_pkg::F_READ: begin
              if (idx_w >= cnt_w) begin
                stat_d = oal_pkg::STAT_RANGE;
              end else begin
                rd_d    = idx_w[AW-1:0];
                state_d = oal_pkg::S_READ;
              end
            end
            oal_pkg::F_FIND: begin
              if (empty) begin
                stat_d = oal_pkg::STAT_NOTFOUND;
              end else begin
                rd_d    = '0;
                state_d = oal_pkg::S_SCAN;
              end
            end
            default: begin
              count_d = '0;
            end
          endcase
        end
      end

      // Walk down from the tail: read one entry, write it one place higher as its read data returns.
      oal_pkg::S_SHIFT_UP: begin
        ram_we_o = mv_q;
        mv_d     = 1'b1;
        wa_d     = rd_q + AW'(1);
        if (rd_q == pos_q) begin
          state_d = oal_pkg::S_MOVE_LAST;
        end else begin
          rd_d = rd_q - AW'(1);
        end
      end

      // Walk up from the head; the word read at the head is the deleted item.
      oal_pkg::S_SHIFT_DN: begin
        ram_we_o = mv_q;
        if (cap_q) begin
          itm_d = ram_rdata_i;
        end
        mv_d = (rd_q != '0);
        cap_d = (rd_q == '0);
        wa_d = rd_q - AW'(1);
        if (rd_q == last_a) begin
          state_d = oal_pkg::S_MOVE_LAST;
        end else begin
          rd_d = rd_q + AW'(1);
        end
      end

      oal_pkg::S_READ: begin
        cap_d   = 1'b1;
        mv_d    = 1'b0;
        state_d = oal_pkg::S_MOVE_LAST;
      end

      // Drains the last word still in flight from the read port.
      oal_pkg::S_MOVE_LAST: begin
        ram_we_o = mv_q;
        if (cap_q) begin
          itm_d = ram_rdata_i;
        end
        mv_d  = 1'b0;
        cap_d = 1'b0;
        if (op_q == oal_pkg::F_INS_HEAD || op_q == oal_pkg::F_INS_TAIL ||
            op_q == oal_pkg::F_INS_IDX) begin
          state_d = oal_pkg::S_PUT;
        end else begin
          if (op_q == oal_pkg::F_DEL_HEAD || op_q == oal_pkg::F_DEL_TAIL) begin
            count_d = cnt_m1;
          end
          state_d = oal_pkg::S_DONE;
        end
      end

      oal_pkg::S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        state_d     = oal_pkg::S_DONE;
      end

      // One read issued and one compare made each cycle; each compare checks the word returned by the previous read.
      oal_pkg::S_SCAN: begin
        chk_d  = 1'b1;
        ca_d   = rd_q;
        lchk_d = (rd_q == last_a);
        if (chk_q && ram_rdata_i == val_q) begin
          fidx_d  = ca_q;
          state_d = oal_pkg::S_DONE;
        end else if (chk_q && lchk_q) begin
          stat_d  = oal_pkg::STAT_NOTFOUND;
          state_d = oal_pkg::S_DONE;
        end else if (rd_q != last_a) begin
          rd_d = rd_q + AW'(1);
        end
      end

      oal_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = oal_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = oal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oal_pkg::S_IDLE;
      count_q <= '0;
      mv_q    <= 1'b0;
      cap_q   <= 1'b0;
      chk_q   <= 1'b0;
      lchk_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mv_q    <= mv_d;
      cap_q   <= cap_d;
      chk_q   <= chk_d;
      lchk_q  <= lchk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    stat_q <= stat_d;
    pos_q  <= pos_d;
    rd_q   <= rd_d;
    wa_q   <= wa_d;
    ca_q   <= ca_d;
    fidx_q <= fidx_d;
    val_q  <= val_d;
    itm_q  <= itm_d;
  end

  assign itm_ext  = 64'(itm_q);
  assign fidx_ext = 64'(fidx_q);
  assign cnt_ext  = 64'(count_q);

  assign res_o.status = stat_q;
  assign res_o.item   = itm_ext[oal_pkg::ITEM_W-1:0];
  assign res_o.index  = fidx_ext[oal_pkg::OIDX_W-1:0];
  assign res_o.length = cnt_ext[oal_pkg::LEN_W-1:0];

endmodule

@@ hw/rtl/ordered_array_list.sv @@
// Top level of the ordered array list: stream ports, capacity register and result register.
//
//  channel   direction  payload
//  s_axis    in         command word: func, index, item
//  m_axis    out        result word: status, item_out, index_out, length_out
//  cfg       in         capacity, 7 bits
//
// Clear and commands that fail at once (full, empty, out of range) go straight to the result;
// an insert at the tail writes the item first, a read or a delete at the tail reads one entry,
// and an insert ahead of the tail, a delete from the head or a find walks the list, paced by
// the single RAM read port that the shift and scan walk one entry a cycle.
// s_axis_tready is low from the cycle after a command is taken until its result has moved
// into the output register; that register holds one finished result while the next
// command is already taken. Reset empties the list and sets the capacity to 64.
module ordered_array_list #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] func, [9:3] index, [41:10] item, [47:42] zero
  input  logic [oal_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] status, [34:3] item_out, [40:35] index_out, [47:41] length_out
  output logic [oal_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [oal_pkg::CAP_W-1:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  oal_pkg::cmd_t cmd;
  oal_pkg::res_t res;
  logic          res_valid, res_ready;
  logic [oal_pkg::CAP_W-1:0] cap_q;
  logic          m_valid_q;
  oal_pkg::res_t m_data_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  assign cmd.func  = oal_pkg::func_e'(s_axis_tdata[2:0]);
  assign cmd.index = s_axis_tdata[9:3];
  assign cmd.item  = s_axis_tdata[41:10];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= oal_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  oal_core #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  oal_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new word whenever it is empty or being emptied.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q.length, m_data_q.index, m_data_q.item, m_data_q.status};

endmodule

@@ hw/rtl/oal_checker.sv @@
// Port-level checks of the ordered array list, bound to the top level.
module oal_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [oal_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A result word waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before it was taken");

  // Every command keeps the block busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block ready again straight after taking a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:41] <= DEPTH)
    else $error("reported length above the list depth");

  // An empty status only comes from a delete on an empty list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == oal_pkg::STAT_EMPTY |->
      m_axis_tdata[47:41] == '0 && m_axis_tdata[34:3] == '0)
    else $error("empty status with items still held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == oal_pkg::STAT_NOTFOUND |->
      m_axis_tdata[40:35] == '0 && m_axis_tdata[34:3] == '0)
    else $error("failed search reports an index or an item");

endmodule

bind ordered_array_list oal_checker #(.DEPTH(DEPTH)) u_oal_checker (.*);

@@ bench/ordered_array_list_tb.sv @@
// Testbench of the ordered array list: directed and random commands checked by a scoreboard.
module ordered_array_list_tb;
  import oal_pkg::*;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 100;

  // Mirror of the list contents and length, with the queue of results still to come.
  class list_scoreboard;
    logic [ITEM_W-1:0] slots [DEPTH];
    int unsigned       held;
    logic [CAP_W-1:0]  cap;
    res_t              awaited_q [$];
    int unsigned       errors;

    function new();
      held = 0;
      cap = CAP_RESET;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned room_limit();
      if (cap == 0 || cap > DEPTH) return DEPTH;
      return cap;
    endfunction

    function void insert_at(int unsigned pos, logic [ITEM_W-1:0] v);
      for (int unsigned i = held; i > pos; i--) slots[i] = slots[i-1];
      slots[pos] = v;
      held++;
    endfunction

    function void note_command(logic [IN_TDATA_W-1:0] word);
      func_e             f;
      int unsigned       pos;
      logic [ITEM_W-1:0] v;
      res_t              r;
      bit                full;
      f = func_e'(word[FUNC_W-1:0]);
      pos = word[FUNC_W +: IDX_W];
      v = word[FUNC_W+IDX_W +: ITEM_W];
      r.status = STAT_OK;
      r.item = '0;
      r.index = '0;
      full = (held >= room_limit());
      case (f)
        F_INS_HEAD, F_INS_TAIL, F_INS_IDX: begin
          // The full test takes precedence over the index range test.
          if (full) r.status = STAT_FULL;
          else if (f == F_INS_HEAD) insert_at(0, v);
          else if (f == F_INS_TAIL) insert_at(held, v);
          else if (pos > held) r.status = STAT_RANGE;
          else insert_at(pos, v);
        end
        F_DEL_HEAD: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.item = slots[0];
            for (int unsigned i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
          end
        end
        F_DEL_TAIL: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.item = slots[held-1];
            held--;
          end
        end
        F_READ: begin
          if (pos >= held) r.status = STAT_RANGE;
          else r.item = slots[pos];
        end
        F_FIND: begin
          r.status = STAT_NOTFOUND;
          for (int unsigned i = 0; i < held; i++) begin
            if (slots[i] == v) begin
              r.status = STAT_OK;
              r.index = OIDX_W'(i);
              break;
            end
          end
        end
        default: held = 0;
      endcase
      r.length = LEN_W'(held);
      awaited_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [ITEM_W-1:0] want, logic [ITEM_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      res_t want;
      if (awaited_q.size() == 0) begin
        $display("%0t: result word %h arrived with none awaited", $time, word);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      compare_field("status", ITEM_W'(want.status), ITEM_W'(word[STAT_W-1:0]));
      compare_field("item_out", want.item, word[STAT_W +: ITEM_W]);
      compare_field("index_out", ITEM_W'(want.index), ITEM_W'(word[STAT_W+ITEM_W +: OIDX_W]));
      compare_field("length_out", ITEM_W'(want.length),
                    ITEM_W'(word[STAT_W+ITEM_W+OIDX_W +: LEN_W]));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CAP_W-1:0]       cfg_data_i = '0;

  list_scoreboard    board = new();
  int unsigned       cycle_count = 0;
  bit                sink_hold_req = 1'b0;
  bit                steady_flow = 1'b0;
  logic [ITEM_W-1:0] common_values [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                           32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_002A,
                                           32'hAAAA_AAAA, 32'h0000_0007};

  ordered_array_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.set_capacity(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) board.note_command(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  // Result side: random ready and stall stretches, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned r;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (steady_flow || r < 65) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk_i);
        else if (r < 98) repeat ($urandom_range(4, 15)) @(posedge clk_i);
        else repeat ($urandom_range(30, 90)) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Called at a rising edge; returns at the edge where the command word is taken.
  task automatic send_cmd(func_e f, logic [IDX_W-1:0] idx, logic [ITEM_W-1:0] v,
                          int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-FUNC_W-IDX_W-ITEM_W){1'b0}}, v, idx, f};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.awaited_q.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned ins_pct, bit no_gap);
    func_e             f;
    int unsigned       r;
    int unsigned       hint;
    logic [IDX_W-1:0]  idx;
    logic [ITEM_W-1:0] v;
    hint = board.held;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      f = func_e'($urandom_range(0, 2));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) f = ($urandom_range(0, 1) != 0) ? F_DEL_HEAD : F_DEL_TAIL;
      else if (r < 70) f = F_READ;
      else if (r < 98) f = F_FIND;
      else f = F_CLEAR;
    end
    // Indexes mostly near the current length, now and then anywhere the field allows.
    r = $urandom_range(0, 9);
    if (r < 8) idx = IDX_W'($urandom_range(0, hint + 1));
    else if (r < 9) idx = IDX_W'($urandom_range(0, DEPTH));
    else idx = IDX_W'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (f == F_FIND && hint != 0 && r < 40) v = board.slots[$urandom_range(0, hint - 1)];
    else if (r < 70) v = common_values[$urandom_range(0, 7)];
    else v = $urandom;
    send_cmd(f, idx, v, no_gap ? 0 : sender_gap());
  endtask

  task automatic run_phase(logic [CAP_W-1:0] capacity, int unsigned n, int unsigned ins_pct,
                           bit press);
    wait_drained();
    write_capacity(capacity);
    if (press) sink_hold_req = 1'b1;
    // Under pressure the first words go back to back so that the block backs up.
    for (int unsigned k = 0; k < n; k++) send_random(ins_pct, press && k < 24);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list cases first, then a short list with both ends and the middle touched.
    send_cmd(F_DEL_HEAD, 7'd0, 32'h0, sender_gap());
    send_cmd(F_DEL_TAIL, 7'd0, 32'h0, sender_gap());
    send_cmd(F_READ, 7'd0, 32'h0, sender_gap());
    send_cmd(F_FIND, 7'd0, 32'h0, sender_gap());
    send_cmd(F_INS_IDX, 7'd1, 32'h1, sender_gap());
    send_cmd(F_INS_HEAD, 7'd0, 32'h8000_0000, sender_gap());
    send_cmd(F_INS_TAIL, 7'd0, 32'h7FFF_FFFF, sender_gap());
    send_cmd(F_INS_IDX, 7'd1, 32'hFFFF_FFFF, sender_gap());
    send_cmd(F_INS_IDX, 7'd3, 32'h0, sender_gap());
    send_cmd(F_INS_IDX, 7'd5, 32'h1, sender_gap());
    send_cmd(F_INS_IDX, 7'd127, 32'h2, sender_gap());
    send_cmd(F_READ, 7'd0, 32'h0, sender_gap());
    send_cmd(F_READ, 7'd3, 32'h0, sender_gap());
    send_cmd(F_READ, 7'd4, 32'h0, sender_gap());
    send_cmd(F_READ, 7'd127, 32'h0, sender_gap());
    send_cmd(F_INS_TAIL, 7'd0, 32'hFFFF_FFFF, sender_gap());
    send_cmd(F_FIND, 7'd0, 32'hFFFF_FFFF, sender_gap());
    send_cmd(F_FIND, 7'd0, 32'h1234_5678, sender_gap());
    send_cmd(F_DEL_HEAD, 7'd0, 32'h0, sender_gap());
    send_cmd(F_DEL_TAIL, 7'd0, 32'h0, sender_gap());
    send_cmd(F_CLEAR, 7'd0, 32'h0, sender_gap());
    send_cmd(F_READ, 7'd0, 32'h0, sender_gap());

    // A capacity of one: the second insert of any kind must report full.
    wait_drained();
    write_capacity(7'd1);
    send_cmd(F_INS_HEAD, 7'd0, 32'h5555_5555, sender_gap());
    send_cmd(F_INS_TAIL, 7'd0, 32'hAAAA_AAAA, sender_gap());
    send_cmd(F_INS_IDX, 7'd5, 32'h3, sender_gap());
    send_cmd(F_DEL_TAIL, 7'd0, 32'h0, sender_gap());

    run_phase(7'd64, 160, 75, 1'b1);
    // The limit drops well below the length held, so inserts stay full for a while.
    run_phase(7'd3, 50, 40, 1'b0);
    run_phase(7'd0, 100, 70, 1'b0);
    steady_flow = 1'b1;
    run_phase(7'd127, 60, 60, 1'b0);
    steady_flow = 1'b0;
    run_phase(7'd1, 50, 50, 1'b0);
    run_phase(7'd5, 60, 50, 1'b0);
    run_phase(7'd64, 120, 25, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.awaited_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
